[rtl/core/blsw_pkg.sv]
// ----------------------------------------------------------------------------
// blsw_pkg
// Shared constants, register codes and types of the banded line sum window.
// ----------------------------------------------------------------------------
package blsw_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_TRACKS = 8;
  localparam int unsigned MAX_SLIT   = 16;

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned TRACKS_W = 4;
  localparam int unsigned SLIT_W   = 5;
  localparam int unsigned TRACK_W  = $clog2(MAX_TRACKS);
  localparam int unsigned SLOT_W   = $clog2(MAX_SLIT);
  localparam int unsigned ACC_W    = 20;
  localparam int unsigned TOTAL_W  = 24;

  localparam int unsigned HIST_DEPTH = MAX_TRACKS * MAX_SLIT;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // scaled column position: up to (MAX_WIDTH + 1) * MAX_TRACKS
  localparam int unsigned POS_W = $clog2((MAX_WIDTH + 2) * MAX_TRACKS + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_TRACK_COUNT  = 2'd1,
    CFG_WINDOW_LINES = 2'd2
  } cfg_index_t;

  localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = WIDTH_W'(4096);
  localparam logic [TRACKS_W-1:0] TRACK_COUNT_RST  = TRACKS_W'(2);
  localparam logic [SLIT_W-1:0]   WINDOW_LINES_RST = SLIT_W'(1);

  // effective (clamped) configuration
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [TRACKS_W-1:0] tracks;
    logic [SLIT_W-1:0]   slit;
  } eff_cfg_t;

  // band end event handed from the band tracker to the window stage
  typedef struct packed {
    logic               valid;
    logic [TRACK_W-1:0] track;
    logic [SLOT_W-1:0]  slot;
    logic [ACC_W-1:0]   sum;
    logic               last;
  } band_done_t;

endpackage

[rtl/core/blsw_pix_if.sv]
// ----------------------------------------------------------------------------
// blsw_pix_if
// Pixel stream channel: valid/ready with one 8-bit pixel.
// ----------------------------------------------------------------------------
interface blsw_pix_if import blsw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/core/blsw_smp_if.sv]
// ----------------------------------------------------------------------------
// blsw_smp_if
// Sample channel: valid/ready with track index, window sum and line end.
// ----------------------------------------------------------------------------
interface blsw_smp_if import blsw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track_index;
  logic [TOTAL_W-1:0] sample;
  logic               line_done;

  modport source (output valid, output track_index, output sample, output line_done,
                  input ready);
  modport sink   (input valid, input track_index, input sample, input line_done,
                  output ready);
endinterface

[rtl/core/blsw_cfg_if.sv]
// ----------------------------------------------------------------------------
// blsw_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface blsw_cfg_if import blsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/banded_line_sum_window_unit.sv]
// ----------------------------------------------------------------------------
// banded_line_sum_window_unit
// Sums pixels over equal-width bands of each line and emits, per band, the
// moving window total of that band over the last window_lines lines.
//
//   channel   dir  payload                              transaction
//   pixels    in   pixel[7:0]                           valid & ready
//   samples   out  track_index[2:0] sample[23:0] line_done  valid & ready
//   cfg       in   index[1:0] data[12:0]                valid & ready
//
// One pixel per cycle while the window stage can take it. A band end reads the
// history memory at its accept edge; when the window stage advances, the entry
// is written back and the result is loaded into the output register.
// Reset and any write to a defined register clear all state at once (history
// by per-entry valid bits), with no clearing pass. A stalled sample holds the
// window stage; pixels keep flowing while the window stage is free.
// ----------------------------------------------------------------------------
module banded_line_sum_window_unit import blsw_pkg::*; (
  input logic   clk,
  input logic   rst,
  blsw_pix_if.sink   pixels,
  blsw_smp_if.source samples,
  blsw_cfg_if.sink   cfg
);

  logic [WIDTH_W-1:0]  line_width;
  logic [TRACKS_W-1:0] track_count;
  logic [SLIT_W-1:0]   window_lines;

  eff_cfg_t            eff;
  logic [TRACKS_W-1:0] t_clamp;
  logic                restart;
  logic                accept;
  logic                take;
  band_done_t          done;

  assign cfg.ready = 1'b1;

  always_comb begin
    case (cfg.index)
      CFG_LINE_WIDTH:   restart = cfg.valid;
      CFG_TRACK_COUNT:  restart = cfg.valid;
      CFG_WINDOW_LINES: restart = cfg.valid;
      default:          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      track_count  <= TRACK_COUNT_RST;
      window_lines <= WINDOW_LINES_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LINE_WIDTH:   line_width   <= cfg.data[WIDTH_W-1:0];
        CFG_TRACK_COUNT:  track_count  <= cfg.data[TRACKS_W-1:0];
        CFG_WINDOW_LINES: window_lines <= cfg.data[SLIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their working ranges; no band may be empty
  always_comb begin
    if (line_width == '0) begin
      eff.width = WIDTH_W'(1);
    end else if (line_width > WIDTH_W'(MAX_WIDTH)) begin
      eff.width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff.width = line_width;
    end

    if (track_count == '0) begin
      t_clamp = TRACKS_W'(1);
    end else if (track_count > TRACKS_W'(MAX_TRACKS)) begin
      t_clamp = TRACKS_W'(MAX_TRACKS);
    end else begin
      t_clamp = track_count;
    end
    if (WIDTH_W'(t_clamp) > eff.width) begin
      eff.tracks = eff.width[TRACKS_W-1:0];
    end else begin
      eff.tracks = t_clamp;
    end

    if (window_lines == '0) begin
      eff.slit = SLIT_W'(1);
    end else if (window_lines > SLIT_W'(MAX_SLIT)) begin
      eff.slit = SLIT_W'(MAX_SLIT);
    end else begin
      eff.slit = window_lines;
    end
  end

  assign pixels.ready = take;
  assign accept       = pixels.valid && take;

  blsw_band_ctl u_band_ctl (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .eff     (eff),
    .accept  (accept),
    .pixel   (pixels.pixel),
    .done    (done)
  );

  blsw_window u_window (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .accept     (accept),
    .done       (done),
    .take       (take),
    .out_ready  (samples.ready),
    .out_valid  (samples.valid),
    .out_track  (samples.track_index),
    .out_sample (samples.sample),
    .out_last   (samples.line_done)
  );

endmodule

[rtl/core/blsw_band_ctl.sv]
// ----------------------------------------------------------------------------
// blsw_band_ctl
// Tracks column, band and ring slot, accumulates the band sum and flags the
// last pixel of each band. Band ends are found without division: column c
// continues band b while (c + 2) * T <= (b + 1) * W, kept as scaled counters.
// ----------------------------------------------------------------------------
module blsw_band_ctl import blsw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  eff_cfg_t           eff,
  input  logic               accept,
  input  logic [PIXEL_W-1:0] pixel,
  output band_done_t         done
);

  logic [TRACK_W-1:0] band;
  logic [ACC_W-1:0]   acc;
  logic [POS_W-1:0]   pos;    // column * T
  logic [POS_W-1:0]   lim;    // band * W
  logic [SLOT_W-1:0]  slot;

  logic [ACC_W-1:0]    acc_sum;
  logic [POS_W-1:0]    t_ext;
  logic [POS_W-1:0]    w_ext;
  logic                cont;
  logic [TRACKS_W-1:0] band_inc;
  logic [SLIT_W-1:0]   slot_inc;

  always_comb begin
    acc_sum  = acc + ACC_W'(pixel);
    t_ext    = POS_W'(eff.tracks);
    w_ext    = POS_W'(eff.width);
    cont     = (pos + (t_ext << 1)) <= (lim + w_ext);
    band_inc = TRACKS_W'(band) + TRACKS_W'(1);
    slot_inc = SLIT_W'(slot) + SLIT_W'(1);

    done.valid = !cont;
    done.track = band;
    done.slot  = slot;
    done.sum   = acc_sum;
    done.last  = band_inc >= eff.tracks;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      band <= '0;
      acc  <= '0;
      pos  <= '0;
      lim  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (cont) begin
        acc <= acc_sum;
        pos <= pos + t_ext;
      end else begin
        acc <= '0;
        if (done.last) begin
          // wrap to the next line and advance the shared ring slot
          band <= '0;
          pos  <= '0;
          lim  <= '0;
          slot <= (slot_inc >= eff.slit) ? '0 : slot_inc[SLOT_W-1:0];
        end else begin
          band <= band_inc[TRACK_W-1:0];
          pos  <= pos + t_ext;
          lim  <= lim + w_ext;
        end
      end
    end
  end

endmodule

[rtl/core/blsw_window.sv]
// ----------------------------------------------------------------------------
// blsw_window
// History memory of band sums per track and ring slot, moving window totals
// and the output register. Read at band end, modify and write back when the
// stage advances; a read meeting the same edge's write takes forwarded data.
// ----------------------------------------------------------------------------
module blsw_window import blsw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic               accept,
  input  band_done_t         done,
  output logic               take,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [TRACK_W-1:0] out_track,
  output logic [TOTAL_W-1:0] out_sample,
  output logic               out_last
);

  logic [ACC_W-1:0]      hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld;
  logic [ACC_W-1:0]      rd_data;
  logic                  rd_vld;

  logic                  lw_vld;
  logic [HIST_AW-1:0]    lw_idx;
  logic [ACC_W-1:0]      lw_data;

  logic [TOTAL_W-1:0]    wt [MAX_TRACKS];
  band_done_t            s1;

  logic                  adv;
  logic                  issue;
  logic                  fire;
  logic [HIST_AW-1:0]    idx0;
  logic [HIST_AW-1:0]    idx1;
  logic [ACC_W-1:0]      old;
  logic [TOTAL_W-1:0]    total;

  always_comb begin
    adv   = !out_valid || out_ready;
    take  = !s1.valid || adv;
    issue = accept && done.valid;
    fire  = s1.valid && adv;
    idx0  = {done.track, done.slot};
    idx1  = {s1.track, s1.slot};
    if (lw_vld && (lw_idx == idx1)) begin
      old = lw_data;
    end else if (rd_vld) begin
      old = rd_data;
    end else begin
      old = '0;
    end
    total = wt[s1.track] + TOTAL_W'(s1.sum) - TOTAL_W'(old);
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= hist_mem[idx0];
    end
    if (fire) begin
      hist_mem[idx1] <= s1.sum;
    end
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      hist_vld <= '0;
      rd_vld   <= 1'b0;
      lw_vld   <= 1'b0;
      lw_idx   <= '0;
      lw_data  <= '0;
    end else begin
      if (issue) begin
        rd_vld <= hist_vld[idx0];
      end
      if (fire) begin
        hist_vld[idx1] <= 1'b1;
        lw_vld         <= 1'b1;
        lw_idx         <= idx1;
        lw_data        <= s1.sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1 <= '0;
    end else if (take) begin
      s1 <= '{valid: issue, track: done.track, slot: done.slot, sum: done.sum,
              last: done.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < MAX_TRACKS; i++) begin
        wt[i] <= '0;
      end
    end else if (fire) begin
      wt[s1.track] <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_track  <= s1.track;
      out_sample <= total;
      out_last   <= s1.last;
    end
  end

endmodule
